### sv/assert_macros.svh
// Assertion helpers for the allocator. All checks are sampled on the rising
// clock edge and are switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define BFA_ASSERT_NOW(name, trig, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// Checks that the condition holds in the cycle after the trigger.
`define BFA_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

### sv/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAX_BLOCKS    = 64;
    localparam int PAGE_BYTES    = 4096;
    localparam int HEADER_BYTES  = 32;
    localparam int HEAP_CAPACITY = 268435456;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = 28;
    localparam int HEAP_W = $clog2(HEAP_CAPACITY + 1);

    localparam logic OP_FREE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NULL_FREE,
        ST_NO_ROOM,
        ST_BAD_FREE
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_TRIM
    } t_state;

    // One row of the block table.
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] size;
        logic             used;
    } t_entry;

endpackage

### sv/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

### sv/best_fit_block_allocator.sv
// An allocate or a free reads the table in S_SCAN (skipped when it is empty); an
// allocate, or a free with no match, ends in S_RESOLVE, a free at its hit, and a
// free of the last block then walks back over the trailing free blocks in S_TRIM,
// one entry per cycle. A null free answers next cycle. One item at a time, paced
// by the single read port of the block table. The receiver cannot stall the result.
// Reset empties the table and the heap; the table memory itself is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_fit_block_allocator
    import bfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [OFF_W-1:0]  i_request_bytes,
    input  logic [OFF_W-1:0]  i_payload_offset,
    output logic              o_done,
    output logic [OFF_W-1:0]  o_result_offset,
    output logic [1:0]        o_status,
    output logic [HEAP_W-1:0] o_heap_bytes_now
);

    localparam int ENTRY_W = $bits(t_entry);

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [OFF_W-1:0]   r_want, n_want;
    logic [OFF_W-1:0]   r_offset, n_offset;
    logic [HEAP_W:0]    r_total, n_total;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [HEAP_W-1:0]  r_heap, n_heap;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic               r_tmore, n_tmore;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [OFF_W-1:0]   r_best_start, n_best_start;
    logic [OFF_W-1:0]   r_best_size, n_best_size;
    logic               r_done, n_done;
    logic [OFF_W-1:0]   r_res_off, n_res_off;
    t_status            r_status, n_status;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    t_entry             ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    logic               accept;
    logic               pend_last;
    logic [HEAP_W:0]    need_rnd;
    logic [HEAP_W+1:0]  app_end;
    logic [HEAP_W:0]    app_pay;
    logic [HEAP_W:0]    trim_end;
    logic [HEAP_W-1:0]  hit_pay;

    // Reads and writes never touch the same entry in one cycle: a write ends
    // each item's table work and the next item reads only after a pass through
    // S_IDLE, so the memory needs no forwarding path.
    bfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = t_entry'(ram_rdata);
    assign accept    = start && !busy;
    assign pend_last = (CNT_W'(r_pidx) + CNT_W'(1)) == r_count;
    assign need_rnd  = (HEAP_W+1)'(i_request_bytes)
                     + (HEAP_W+1)'(HEADER_BYTES + PAGE_BYTES - 1);
    assign app_end   = (HEAP_W+2)'(r_heap) + (HEAP_W+2)'(r_total);
    assign app_pay   = (HEAP_W+1)'(r_heap) + (HEAP_W+1)'(HEADER_BYTES);
    assign trim_end  = (HEAP_W+1)'(rd_entry.start) + (HEAP_W+1)'(HEADER_BYTES)
                     + (HEAP_W+1)'(rd_entry.size);
    assign hit_pay   = HEAP_W'(rd_entry.start) + HEAP_W'(HEADER_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_heap  <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_tmore <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_heap  <= n_heap;
            r_done  <= n_done;
            r_pend  <= n_pend;
            r_tmore <= n_tmore;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_want       <= n_want;
        r_offset     <= n_offset;
        r_total      <= n_total;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_best_idx   <= n_best_idx;
        r_best_start <= n_best_start;
        r_best_size  <= n_best_size;
        r_res_off    <= n_res_off;
        r_status     <= n_status;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_want       = r_want;
        n_offset     = r_offset;
        n_total      = r_total;
        n_count      = r_count;
        n_heap       = r_heap;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_tmore      = r_tmore;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_start = r_best_start;
        n_best_size  = r_best_size;
        n_done       = 1'b0;
        n_res_off    = r_res_off;
        n_status     = r_status;
        ram_we       = 1'b0;
        ram_waddr    = r_best_idx;
        ram_wdata    = '{start: r_best_start, size: r_best_size, used: 1'b1};
        ram_re       = 1'b0;
        ram_raddr    = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_operation;
                    n_want   = i_request_bytes;
                    n_offset = i_payload_offset;
                    n_total  = need_rnd & ~((HEAP_W+1)'(PAGE_BYTES - 1));
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                    if (i_operation == OP_FREE && i_payload_offset == '0) begin
                        n_done    = 1'b1;
                        n_res_off = '0;
                        n_status  = ST_NULL_FREE;
                    end else if (r_count == '0) begin
                        n_state = S_RESOLVE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Reads go out one entry per cycle; each is judged in the cycle after its read.
                ram_re = r_idx < r_count;
                n_pend = ram_re;
                n_pidx = r_idx[IDX_W-1:0];
                n_idx  = r_idx + CNT_W'(1);
                if (r_pend) begin
                    if (r_op != OP_FREE) begin
                        if (!rd_entry.used && rd_entry.size >= r_want &&
                            (!r_found || rd_entry.size < r_best_size)) begin
                            n_found      = 1'b1;
                            n_best_idx   = r_pidx;
                            n_best_start = rd_entry.start;
                            n_best_size  = rd_entry.size;
                        end
                        if (pend_last) begin
                            n_state = S_RESOLVE;
                        end
                    end else if (rd_entry.used && hit_pay == HEAP_W'(r_offset)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pidx;
                        ram_wdata = '{start: rd_entry.start, size: rd_entry.size,
                                      used: 1'b0};
                        n_res_off = '0;
                        n_status  = ST_OK;
                        if (!pend_last) begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end else if (r_pidx == '0) begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_count = '0;
                            n_heap  = '0;
                        end else begin
                            // The last block went free: walk back to the last used one.
                            n_state = S_TRIM;
                            n_idx   = CNT_W'(r_pidx) - CNT_W'(1);
                            n_tmore = 1'b1;
                            n_pend  = 1'b0;
                        end
                    end else if (pend_last) begin
                        n_state = S_RESOLVE;
                    end
                end
            end

            S_RESOLVE: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_op == OP_FREE) begin
                    n_res_off = '0;
                    n_status  = ST_BAD_FREE;
                end else if (r_found) begin
                    ram_we    = 1'b1;
                    n_res_off = r_best_start + OFF_W'(HEADER_BYTES);
                    n_status  = ST_OK;
                end else if (r_count >= CNT_W'(MAX_BLOCKS) ||
                             app_end > (HEAP_W+2)'(HEAP_CAPACITY) ||
                             app_pay[HEAP_W:OFF_W] != '0) begin
                    n_res_off = '0;
                    n_status  = ST_NO_ROOM;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    ram_wdata = '{start: r_heap[OFF_W-1:0],
                                  size: OFF_W'(r_total - (HEAP_W+1)'(HEADER_BYTES)),
                                  used: 1'b1};
                    n_count   = r_count + CNT_W'(1);
                    n_heap    = app_end[HEAP_W-1:0];
                    n_res_off = app_pay[OFF_W-1:0];
                    n_status  = ST_OK;
                end
            end

            S_TRIM: begin
                ram_re = r_tmore;
                n_pend = r_tmore;
                n_pidx = r_idx[IDX_W-1:0];
                if (r_tmore) begin
                    if (r_idx == '0) begin
                        n_tmore = 1'b0;
                    end else begin
                        n_idx = r_idx - CNT_W'(1);
                    end
                end
                if (r_pend) begin
                    if (rd_entry.used) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        n_count = CNT_W'(r_pidx) + CNT_W'(1);
                        n_heap  = trim_end[HEAP_W-1:0];
                    end else if (r_pidx == '0) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        n_count = '0;
                        n_heap  = '0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = r_state != S_IDLE;
    assign o_done           = r_done;
    assign o_result_offset  = r_res_off;
    assign o_status         = r_status;
    assign o_heap_bytes_now = r_heap;

    `BFA_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= CNT_W'(MAX_BLOCKS), "block count overflow")
    `BFA_ASSERT_NOW(a_empty_heap, r_count == '0, r_heap == '0, "heap not empty with no blocks")
    `BFA_ASSERT_NOW(a_heap_nonzero, r_count != '0, r_heap != '0, "heap empty with blocks")
    `BFA_ASSERT_NOW(a_fail_no_offset, o_done && r_status != ST_OK, o_result_offset == '0, "offset on failure")
    `BFA_ASSERT_NEXT(a_busy_after_start, accept && !(i_operation == OP_FREE && i_payload_offset == '0), busy, "no work after start")

endmodule

### tb/best_fit_block_allocator_checker.sv
`timescale 1ns / 1ps

module best_fit_block_allocator_checker
    import bfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_operation,
    input  logic [OFF_W-1:0]  i_request_bytes,
    input  logic [OFF_W-1:0]  i_payload_offset,
    input  logic              i_done,
    input  logic [OFF_W-1:0]  i_result_offset,
    input  logic [1:0]        i_status,
    input  logic [HEAP_W-1:0] i_heap_bytes_now,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results_seen,
    output int                o_no_room_seen,
    output int                o_bad_free_seen,
    output int                o_peak_blocks
);

    typedef struct {
        logic [OFF_W-1:0]  offset;
        t_status           status;
        logic [HEAP_W-1:0] heap;
    } t_heap_answer;

    // Shadow copy of the block table and the heap end.
    logic [OFF_W-1:0]  blk_start [MAX_BLOCKS];
    logic [OFF_W-1:0]  blk_size  [MAX_BLOCKS];
    logic              blk_used  [MAX_BLOCKS];
    int unsigned       blk_count = 0;
    logic [HEAP_W-1:0] heap_end  = '0;

    t_heap_answer answers_due[$];
    int fails     = 0;
    int results   = 0;
    int no_room   = 0;
    int bad_frees = 0;
    int peak      = 0;

    function automatic t_heap_answer serve_alloc(logic [OFF_W-1:0] want);
        t_heap_answer    ans;
        int              best;
        longint unsigned need;
        longint unsigned total;
        longint unsigned base;
        best = -1;
        for (int i = 0; i < int'(blk_count); i++) begin
            if (!blk_used[i] && blk_size[i] >= want) begin
                if (best < 0 || blk_size[best] > blk_size[i])
                    best = i;
            end
        end
        if (best >= 0) begin
            blk_used[best] = 1'b1;
            ans.offset     = blk_start[best] + OFF_W'(HEADER_BYTES);
            ans.status     = ST_OK;
        end else begin
            // Nothing free fits, so a page-rounded block goes on the heap end if there is room.
            need  = 64'(want) + 64'(HEADER_BYTES);
            total = (need + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES) * 64'(PAGE_BYTES);
            base  = 64'(heap_end);
            if (blk_count >= MAX_BLOCKS || base + total > 64'(HEAP_CAPACITY) ||
                base + 64'(HEADER_BYTES) >= (64'd1 << OFF_W)) begin
                ans.offset = '0;
                ans.status = ST_NO_ROOM;
            end else begin
                blk_start[blk_count] = OFF_W'(base);
                blk_size[blk_count]  = OFF_W'(total - 64'(HEADER_BYTES));
                blk_used[blk_count]  = 1'b1;
                blk_count++;
                heap_end   = HEAP_W'(base + total);
                ans.offset = OFF_W'(base + 64'(HEADER_BYTES));
                ans.status = ST_OK;
            end
        end
        ans.heap = heap_end;
        return ans;
    endfunction

    function automatic t_heap_answer serve_free(logic [OFF_W-1:0] off);
        t_heap_answer ans;
        int           hit;
        ans.offset = '0;
        hit        = -1;
        if (off == '0) begin
            ans.status = ST_NULL_FREE;
        end else begin
            for (int i = 0; i < int'(blk_count); i++) begin
                if (hit < 0 && blk_used[i] &&
                    64'(blk_start[i]) + 64'(HEADER_BYTES) == 64'(off))
                    hit = i;
            end
            if (hit < 0) begin
                ans.status = ST_BAD_FREE;
            end else begin
                ans.status    = ST_OK;
                blk_used[hit] = 1'b0;
                // Freeing the last block drops every free block behind it.
                if (hit + 1 == int'(blk_count)) begin
                    while (blk_count > 0 && !blk_used[blk_count - 1])
                        blk_count--;
                    if (blk_count == 0)
                        heap_end = '0;
                    else
                        heap_end = HEAP_W'(64'(blk_start[blk_count - 1]) +
                                           64'(HEADER_BYTES) +
                                           64'(blk_size[blk_count - 1]));
                end
            end
        end
        ans.heap = heap_end;
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_heap_answer want_ans;
        if (!i_rst_n) begin
            blk_count = 0;
            heap_end  = '0;
            answers_due.delete();
        end else begin
            if (i_done) begin
                results++;
                if (i_status == ST_NO_ROOM)
                    no_room++;
                if (i_status == ST_BAD_FREE)
                    bad_frees++;
                if (answers_due.size() == 0) begin
                    $error("result with no item outstanding: offset %0d status %0d heap %0d",
                           i_result_offset, i_status, i_heap_bytes_now);
                    fails++;
                end else begin
                    want_ans = answers_due.pop_front();
                    if (i_result_offset !== want_ans.offset) begin
                        $error("result_offset: expected %0d, got %0d",
                               want_ans.offset, i_result_offset);
                        fails++;
                    end
                    if (i_status !== want_ans.status) begin
                        $error("status: expected %0d, got %0d", want_ans.status, i_status);
                        fails++;
                    end
                    if (i_heap_bytes_now !== want_ans.heap) begin
                        $error("heap_bytes_now: expected %0d, got %0d",
                               want_ans.heap, i_heap_bytes_now);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_operation == OP_FREE)
                    answers_due.push_back(serve_free(i_payload_offset));
                else
                    answers_due.push_back(serve_alloc(i_request_bytes));
                if (int'(blk_count) > peak)
                    peak = int'(blk_count);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= answers_due.size();
        o_results_seen  <= results;
        o_no_room_seen  <= no_room;
        o_bad_free_seen <= bad_frees;
        o_peak_blocks   <= peak;
    end

endmodule

### tb/best_fit_block_allocator_tb.sv
`timescale 1ns / 1ps

module best_fit_block_allocator_tb;
    import bfa_pkg::*;

    localparam logic        OP_ALLOC    = ~OP_FREE;
    localparam int          MAX_REQUEST = HEAP_CAPACITY - HEADER_BYTES;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              start            = 1'b0;
    logic              busy;
    logic              i_operation      = OP_ALLOC;
    logic [OFF_W-1:0]  i_request_bytes  = '0;
    logic [OFF_W-1:0]  i_payload_offset = '0;
    logic              o_done;
    logic [OFF_W-1:0]  o_result_offset;
    logic [1:0]        o_status;
    logic [HEAP_W-1:0] o_heap_bytes_now;

    int fail_count;
    int pending;
    int results_seen;
    int no_room_seen;
    int bad_free_seen;
    int peak_blocks;

    int unsigned      cycle_count = 0;
    int               idle_pct    = 0;
    logic [OFF_W-1:0] live_offsets[$];

    best_fit_block_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_payload_offset (i_payload_offset),
        .o_done           (o_done),
        .o_result_offset  (o_result_offset),
        .o_status         (o_status),
        .o_heap_bytes_now (o_heap_bytes_now)
    );

    best_fit_block_allocator_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_payload_offset (i_payload_offset),
        .i_done           (o_done),
        .i_result_offset  (o_result_offset),
        .i_status         (o_status),
        .i_heap_bytes_now (o_heap_bytes_now),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_seen   (results_seen),
        .o_no_room_seen   (no_room_seen),
        .o_bad_free_seen  (bad_free_seen),
        .o_peak_blocks    (peak_blocks)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Up to 200 recent payload offsets handed out feed the frees; stale ones give double frees.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && o_status == ST_OK && o_result_offset != '0) begin
            live_offsets.push_back(o_result_offset);
            if (live_offsets.size() > 200)
                void'(live_offsets.pop_front());
        end
    end

    task automatic issue_item(input logic op, input logic [OFF_W-1:0] req,
                              input logic [OFF_W-1:0] off);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_operation      <= op;
        i_request_bytes  <= req;
        i_payload_offset <= off;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic random_item(input int alloc_pct);
        logic [OFF_W-1:0] req;
        logic [OFF_W-1:0] off;
        int               roll;
        int               idx;
        req  = OFF_W'($urandom_range(0, MAX_REQUEST));
        off  = OFF_W'($urandom);
        roll = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
            // Mostly small requests so the table fills before the heap does.
            if (roll < 5)
                req = '0;
            else if (roll < 75)
                req = OFF_W'($urandom_range(0, 12000));
            else if (roll < 95)
                req = OFF_W'($urandom_range(0, 1 << 20));
            issue_item(OP_ALLOC, req, off);
        end else begin
            if (roll < 75 && live_offsets.size() != 0) begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                off = live_offsets[idx];
                if ($urandom_range(9) < 8)
                    live_offsets.delete(idx);
            end else if (roll < 85) begin
                off = '0;
            end else if (roll < 92) begin
                off = OFF_W'($urandom_range(0, 1023) * PAGE_BYTES + HEADER_BYTES);
            end
            issue_item(OP_FREE, req, off);
        end
    endtask

    initial begin
        int idle_plan[4];
        idle_plan = '{0, 68, 0, 17};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Frees on an empty heap: a null pointer, then an offset of all ones.
        issue_item(OP_FREE, '0, '0);
        issue_item(OP_FREE, '1, '1);
        // Zero-byte request, a request that fills a page exactly, one just over.
        issue_item(OP_ALLOC, '0, '0);
        issue_item(OP_ALLOC, OFF_W'(PAGE_BYTES - HEADER_BYTES), '0);
        issue_item(OP_ALLOC, OFF_W'(PAGE_BYTES - HEADER_BYTES + 1), '0);
        issue_item(OP_ALLOC, '0, '0);
        // Free the first and third blocks, then a double free.
        issue_item(OP_FREE, '0, 28'd32);
        issue_item(OP_FREE, '0, 28'd8224);
        issue_item(OP_FREE, '0, 28'd32);
        // Best fit picks the smaller free block, here also the first one.
        issue_item(OP_ALLOC, 28'd100, '0);
        issue_item(OP_FREE, '0, 28'd4128);
        issue_item(OP_FREE, '0, 28'd8224);
        // Free blocks of 4064 and 8160 bytes: the smaller one, at the lower index, wins.
        issue_item(OP_ALLOC, 28'd50, '0);
        // A free of an offset that no block holds, then a free of a block in the middle.
        issue_item(OP_FREE, '0, 28'd12320);
        issue_item(OP_FREE, '0, 28'd4128);
        // The largest request would need the whole heap, so with blocks on it, it gets no room.
        issue_item(OP_ALLOC, OFF_W'(MAX_REQUEST), '1);
        issue_item(OP_ALLOC, '0, '0);
        issue_item(OP_FREE, '0, 28'd33);
        issue_item(OP_FREE, '0, 28'd32);
        issue_item(OP_ALLOC, 28'd4096, '0);
        issue_item(OP_ALLOC, OFF_W'(MAX_REQUEST), '0);
        issue_item(OP_FREE, '1, 28'd32);

        // The receiver cannot stall results; each phase sets how often the sender idles before an item.
        foreach (idle_plan[p]) begin
            idle_pct = idle_plan[p];
            repeat (80) random_item(90);
            repeat (40) random_item(25);
            repeat (68) random_item(55);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Checked %0d results: %0d allocations refused for room, %0d bad frees.",
                 results_seen, no_room_seen, bad_free_seen);
        $display("Block table reached %0d of %0d entries.", peak_blocks, MAX_BLOCKS);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/best_fit_block_allocator.sv
tb/best_fit_block_allocator_checker.sv
tb/best_fit_block_allocator_tb.sv
